### rtl/pnps_pkg.sv
package pnps_pkg;

  // Field widths.
  localparam int COORD_W       = 32;
  localparam int AXES          = 3;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int RECORD_W      = 20;
  localparam int MAX_RECORDS   = 1 << RECORD_W;
  localparam int DIST_W        = 63;

  // Datapath widths.
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MUL_W     = COORD_W + 2;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 2 * DIFF_W;
  localparam int ERR_W     = COORD_W + 3;
  localparam int DIV_CNT_W = $clog2(FRACTION_BITS);

  localparam logic [DIST_W-1:0] DIST_LIMIT = {DIST_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(1) << FRACTION_BITS;

  // Stream payload widths.
  localparam int IN_FIELDS_W  = AXES * COORD_W + AXES;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = RECORD_W + FRAC_W + DIST_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_X    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_Y    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_Z    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_QUERY_AXIS = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### rtl/pnps_mul.sv
// Shared unsigned multiplier with a registered product.
module pnps_mul
  import pnps_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

### rtl/pnps_div.sv
// Radix-2 restoring divider for the projection fraction. The numerator is
// below the denominator, so the quotient is purely fractional; one bit is
// produced per cycle.
module pnps_div
  import pnps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ACC_W-1:0]         num,
  input  logic [ACC_W-1:0]         den,
  output div_status_t              st,
  output logic [FRACTION_BITS-1:0] quot
);

  logic [ACC_W-1:0]         rem_r;
  logic [ACC_W-1:0]         den_r;
  logic [FRACTION_BITS-1:0] quot_r;
  logic [DIV_CNT_W-1:0]     cnt_r;
  logic                     busy_r;
  logic                     done_r;

  logic [ACC_W:0] shifted;
  logic [ACC_W:0] diff;
  logic           ge;

  always_comb begin
    shifted = {rem_r, 1'b0};
    ge      = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(FRACTION_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[ACC_W-1:0] : shifted[ACC_W-1:0];
      quot_r <= {quot_r[FRACTION_BITS-2:0], ge};
    end
  end

  assign st.busy = busy_r;
  assign st.done = done_r;
  assign quot    = quot_r;

endmodule

### rtl/polyline_nearest_point_search_unit.sv
// Nearest point on a streamed toolpath. Each input beat is one record; a
// segment record is a straight move from the current point to its target,
// and the query position (to be written through the cfg_ port only while
// the block is idle; the block does not enforce this) is projected onto
// it with the fraction clamped to 0..1. The block keeps the smallest
// squared distance (Q31.32, saturated), the record index and the Q1.16
// fraction, and the beat that carries in_tlast produces one result beat
// and restarts the search; the query registers are kept. One record is
// worked on at a time and in_tready is low meanwhile. A record that is
// not a segment, or a segment skipped because a queried axis is unknown,
// goes from the difference step to the final step, and a zero-length one
// from the comparison. A qualifying segment goes through the divider
// unless the fraction clamps to 0 or to 1. The radix-2 divider makes one
// fraction bit per cycle, and the single 34x34 multiplier is used twice
// per axis for the projection and twice per axis for the point error. A
// result waits in an output register, so the next records are taken while
// it is not yet consumed; only a second final record stalls until it is.
module polyline_nearest_point_search_unit
  import pnps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input records.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: target_x[31:0], target_y[63:32], target_z[95:64],
  // target_axis_valid[98:96], zero fill.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: is_segment.
  input  logic                  in_tuser,
  // last_record.
  input  logic                  in_tlast,
  // Results.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: record_index[19:0], fraction[36:20],
  // distance_sq[99:37], zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Fields from bit 0: found.
  output logic                  out_tuser,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIFF  = 13'b0000000000010,
    S_PROD  = 13'b0000000000100,
    S_DRAIN = 13'b0000000001000,
    S_CMP   = 13'b0000000010000,
    S_CMP2  = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_OMUL  = 13'b0000010000000,
    S_ERR   = 13'b0000100000000,
    S_SQ    = 13'b0001000000000,
    S_SACC  = 13'b0010000000000,
    S_CAND  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  localparam logic [2:0] LAST_STEP = 3'(2 * AXES - 1);
  localparam logic [1:0] LAST_AXIS = 2'(AXES - 1);

  function automatic logic [DIFF_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
    mag_d = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic [ERR_W-2:0] mag_e(input logic signed [ERR_W-1:0] v);
    logic [ERR_W-1:0] m;
    m = v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
    mag_e = m[ERR_W-2:0];
  endfunction

  state_t state_r, state_nxt;

  // Query registers.
  logic signed [COORD_W-1:0] query_r [AXES];
  logic [AXES-1:0]           qvalid_r;

  // Search state.
  logic signed [COORD_W-1:0] cur_r [AXES];
  logic [AXES-1:0]           cur_v_r;
  logic [DIST_W-1:0]         best_dist_r;
  logic [RECORD_W-1:0]       best_idx_r;
  logic [FRAC_W-1:0]         best_frac_r;
  logic                      best_found_r;
  logic [RECORD_W-1:0]       cnt_r;

  // Current record.
  logic signed [COORD_W-1:0] tgt_r [AXES];
  logic [AXES-1:0]           tv_r;
  logic                      seg_r;
  logic                      last_r;
  logic                      blocked_r;

  // Working registers.
  logic signed [DIFF_W-1:0] dq_r [AXES];
  logic signed [DIFF_W-1:0] dt_r [AXES];
  logic [ACC_W-1:0]         pp_r, pn_r, tt_r, num_r;
  logic [2:0]               step_r;
  logic                     acc_v_r, acc_kind_r, acc_neg_r;
  logic [FRAC_W-1:0]        frac_r;
  logic [1:0]               axis_r;
  logic [MUL_W-1:0]         emag_r;
  logic [DIST_W-1:0]        dist_r;

  // Result register.
  logic                out_valid_r;
  logic                out_found_r;
  logic [RECORD_W-1:0] out_idx_r;
  logic [FRAC_W-1:0]   out_frac_r;
  logic [DIST_W-1:0]   out_dist_r;

  // Shared units.
  logic                     mul_en;
  logic [MUL_W-1:0]         mul_a, mul_b;
  logic [PROD_W-1:0]        prod_r;
  logic                     div_start;
  div_status_t              div_st;
  logic [FRACTION_BITS-1:0] div_quot;

  // Combinational helpers.
  logic                      blocked_c, usable_c;
  logic signed [COORD_W-1:0] et_c [AXES];
  logic signed [DIFF_W-1:0]  dq_c [AXES];
  logic signed [DIFF_W-1:0]  dt_c [AXES];
  logic [1:0]                pk;
  logic [DIFF_W-1:0]         off_mag;
  logic [ERR_W-1:0]          off_ext;
  logic signed [ERR_W-1:0]   off_s, err_c;
  logic [PROD_W:0]           sum_c;
  logic [DIST_W-1:0]         dist_sat;
  logic                      fin_go;
  logic [RECORD_W-1:0]       cnt_inc;

  pnps_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod_r)
  );

  pnps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (tt_r),
    .st    (div_st),
    .quot  (div_quot)
  );

  // Axis checks and per-axis deltas. A queried axis whose target is absent
  // takes the current value; unqueried axes are forced to zero so that they
  // add nothing in any later step.
  always_comb begin
    blocked_c = |(qvalid_r & ~tv_r & ~cur_v_r);
    usable_c  = ~|(qvalid_r & tv_r & ~cur_v_r);
    for (int k = 0; k < AXES; k++) begin
      et_c[k] = tv_r[k] ? tgt_r[k] : cur_r[k];
      dq_c[k] = qvalid_r[k] ? ({query_r[k][COORD_W-1], query_r[k]} -
                               {cur_r[k][COORD_W-1], cur_r[k]}) : '0;
      dt_c[k] = qvalid_r[k] ? ({et_c[k][COORD_W-1], et_c[k]} -
                               {cur_r[k][COORD_W-1], cur_r[k]}) : '0;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    pk     = step_r[2:1];
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_PROD: begin
        // Even steps form |dq|*|dt|, odd steps |dt|*|dt|.
        mul_en = 1'b1;
        mul_a  = {1'b0, step_r[0] ? mag_d(dt_r[pk]) : mag_d(dq_r[pk])};
        mul_b  = {1'b0, mag_d(dt_r[pk])};
      end
      S_OMUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, mag_d(dt_r[axis_r])};
        mul_b  = {{(MUL_W-FRAC_W){1'b0}}, frac_r};
      end
      S_SQ: begin
        mul_en = 1'b1;
        mul_a  = emag_r;
        mul_b  = emag_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Point error on the current axis and the saturating distance sum.
  always_comb begin
    off_mag  = prod_r[FRACTION_BITS +: DIFF_W];
    off_ext  = {{(ERR_W-DIFF_W){1'b0}}, off_mag};
    off_s    = dt_r[axis_r][DIFF_W-1] ? -off_ext : off_ext;
    err_c    = {{(ERR_W-DIFF_W){dq_r[axis_r][DIFF_W-1]}}, dq_r[axis_r]} - off_s;
    sum_c    = (PROD_W+1)'(dist_r) + (PROD_W+1)'(prod_r);
    dist_sat = (sum_c > (PROD_W+1)'(DIST_LIMIT)) ? DIST_LIMIT : sum_c[DIST_W-1:0];
  end

  assign div_start = (state_r == S_CMP2) && !(num_r >= tt_r);
  assign fin_go    = (state_r == S_FIN) && !(last_r && out_valid_r && !out_tready);
  assign cnt_inc   = (cnt_r == RECORD_W'(MAX_RECORDS - 1)) ? '0 : cnt_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = (!seg_r || blocked_c || !usable_c) ? S_FIN : S_PROD;
      S_PROD:  if (step_r == LAST_STEP) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_CMP;
      S_CMP: begin
        if (tt_r == '0) begin
          state_nxt = S_FIN;
        end else if (pn_r >= pp_r) begin
          state_nxt = S_OMUL;
        end else begin
          state_nxt = S_CMP2;
        end
      end
      S_CMP2:  state_nxt = (num_r >= tt_r) ? S_OMUL : S_DIV;
      S_DIV:   if (div_st.done) state_nxt = S_OMUL;
      S_OMUL:  state_nxt = S_ERR;
      S_ERR:   state_nxt = S_SQ;
      S_SQ:    state_nxt = (axis_r == LAST_AXIS) ? S_SACC : S_OMUL;
      S_SACC:  state_nxt = S_CAND;
      S_CAND:  state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and search state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      for (int k = 0; k < AXES; k++) begin
        query_r[k] <= '0;
        cur_r[k]   <= '0;
      end
      qvalid_r     <= '1;
      cur_v_r      <= '0;
      best_dist_r  <= DIST_LIMIT;
      best_idx_r   <= '0;
      best_frac_r  <= '0;
      best_found_r <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      acc_v_r      <= 1'b0;
      step_r       <= '0;
      axis_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_QUERY_X:    query_r[0] <= $signed(cfg_wdata);
          REG_QUERY_Y:    query_r[1] <= $signed(cfg_wdata);
          REG_QUERY_Z:    query_r[2] <= $signed(cfg_wdata);
          REG_QUERY_AXIS: qvalid_r   <= cfg_wdata[AXES-1:0];
          default:        qvalid_r   <= qvalid_r;
        endcase
      end

      unique case (state_r)
        S_DIFF: begin
          acc_v_r <= 1'b0;
          step_r  <= '0;
        end
        S_PROD: begin
          acc_v_r <= 1'b1;
          step_r  <= step_r + 1'b1;
        end
        S_DRAIN: acc_v_r <= 1'b0;
        S_CMP:   axis_r  <= '0;
        S_SQ:    if (axis_r != LAST_AXIS) axis_r <= axis_r + 1'b1;
        S_CAND: begin
          // A candidate replaces the best when none is kept yet or when strictly closer.
          if (!best_found_r || dist_r < best_dist_r) begin
            best_found_r <= 1'b1;
            best_dist_r  <= dist_r;
            best_idx_r   <= cnt_r;
            best_frac_r  <= frac_r;
          end
        end
        default: begin
          acc_v_r <= acc_v_r;
        end
      endcase

      if (fin_go) begin
        if (last_r) begin
          // The final record restarts the search.
          for (int k = 0; k < AXES; k++) cur_r[k] <= '0;
          cur_v_r      <= '0;
          best_dist_r  <= DIST_LIMIT;
          best_idx_r   <= '0;
          best_frac_r  <= '0;
          best_found_r <= 1'b0;
          cnt_r        <= '0;
        end else begin
          if (seg_r && !blocked_r) begin
            for (int k = 0; k < AXES; k++) begin
              if (tv_r[k]) cur_r[k] <= tgt_r[k];
            end
            cur_v_r <= cur_v_r | tv_r;
          end
          cnt_r <= cnt_inc;
        end
      end

      if (fin_go && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      tgt_r[0] <= $signed(in_tdata[0*COORD_W +: COORD_W]);
      tgt_r[1] <= $signed(in_tdata[1*COORD_W +: COORD_W]);
      tgt_r[2] <= $signed(in_tdata[2*COORD_W +: COORD_W]);
      tv_r     <= in_tdata[AXES*COORD_W +: AXES];
      seg_r    <= in_tuser;
      last_r   <= in_tlast;
    end

    if (state_r == S_DIFF) begin
      blocked_r <= blocked_c;
      for (int k = 0; k < AXES; k++) begin
        dq_r[k] <= dq_c[k];
        dt_r[k] <= dt_c[k];
      end
      pp_r <= '0;
      pn_r <= '0;
      tt_r <= '0;
    end

    if (state_r == S_PROD) begin
      acc_kind_r <= step_r[0];
      acc_neg_r  <= dq_r[pk][DIFF_W-1] ^ dt_r[pk][DIFF_W-1];
    end

    // Accumulate the product issued in the previous cycle.
    if (acc_v_r && (state_r == S_PROD || state_r == S_DRAIN)) begin
      if (acc_kind_r) begin
        tt_r <= tt_r + prod_r[ACC_W-1:0];
      end else if (acc_neg_r) begin
        pn_r <= pn_r + prod_r[ACC_W-1:0];
      end else begin
        pp_r <= pp_r + prod_r[ACC_W-1:0];
      end
    end

    if (state_r == S_CMP) begin
      dist_r <= '0;
      num_r  <= pp_r - pn_r;
      if (pn_r >= pp_r) frac_r <= '0;
    end
    if (state_r == S_CMP2 && num_r >= tt_r) frac_r <= FRAC_ONE;
    if (state_r == S_DIV && div_st.done) frac_r <= {1'b0, div_quot};

    // The square of the previous axis is still in the product register.
    if ((state_r == S_OMUL && axis_r != '0) || state_r == S_SACC) begin
      dist_r <= dist_sat;
    end
    if (state_r == S_ERR) emag_r <= mag_e(err_c);

    if (fin_go && last_r) begin
      out_found_r <= best_found_r;
      out_idx_r   <= best_found_r ? best_idx_r : '0;
      out_frac_r  <= best_found_r ? best_frac_r : '0;
      out_dist_r  <= best_found_r ? best_dist_r : '0;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                       out_dist_r, out_frac_r, out_idx_r};

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_cand_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CAND |=> best_found_r)
    else $error("candidate evaluated but no best kept");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    best_found_r |-> best_frac_r <= FRAC_ONE)
    else $error("best fraction above one");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("result without a segment carries nonzero data");

endmodule

### sim/tb_polyline_nearest_point_search_unit.sv
module tb_polyline_nearest_point_search_unit;
  import pnps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is bounded by this many clock cycles. The slowest correct run
  // streams about 1700 records, with source gaps, result stalls and the
  // pauses between phases.
  localparam int unsigned CYCLE_LIMIT = 600_000;
  // This is the pause after the last result of a phase. It covers the longest
  // record with some margin.
  localparam int SETTLE_CYCLES = 64;
  // This is the target size of the random part, counted in records.
  localparam int RANDOM_RECORDS = 1400;

  // One toolpath record as it travels on the input stream.
  typedef struct packed {
    logic              seg;
    logic [2:0][31:0]  tgt;   // [0] is x, [1] is y, [2] is z
    logic [2:0]        tv;
    logic              last;
  } rec_t;

  // One search result as it travels on the result stream.
  typedef struct packed {
    logic                found;
    logic [RECORD_W-1:0] idx;
    logic [FRAC_W-1:0]   frac;
    logic [DIST_W-1:0]   dsq;
  } nearest_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  polyline_nearest_point_search_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // The clock has a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Records waiting to be driven, and the search results still owed by the
  // block, oldest first.
  rec_t     pending [$];
  nearest_t nearest_q [$];

  // This is the testbench's copy of the query registers.
  longint     qry_pos [3];
  logic [2:0] qry_axes;

  // This is the search state of the toolpath currently streaming.
  longint              pos_now [3];
  logic [2:0]          pos_known;
  logic [DIST_W-1:0]   best_dsq;
  logic [RECORD_W-1:0] best_rec;
  logic [FRAC_W-1:0]   best_frac;
  logic                best_hit;
  logic [RECORD_W-1:0] rec_count;

  int          beats_in = 0;
  int          results_seen = 0;
  int          hits_seen = 0;
  int          miss_count = 0;
  int unsigned cycles = 0;
  logic        steady;

  // Both sides stop idling for a stretch of the run. The window is keyed to
  // accepted input beats, and that counter only changes through nonblocking
  // writes, so the driver and the monitor see the same value at an edge.
  assign steady = (beats_in >= 500) && (beats_in < 800);

  function automatic logic [127:0] mag(input longint v);
    if (v < 0) return 128'(-v);
    return 128'(v);
  endfunction

  // This is the state at the start of every toolpath, both after reset and
  // after each result.
  function automatic void clear_path();
    int k;
    for (k = 0; k < 3; k++) pos_now[k] = 0;
    pos_known = '0;
    best_dsq  = DIST_LIMIT;
    best_rec  = '0;
    best_frac = '0;
    best_hit  = 1'b0;
    rec_count = '0;
  endfunction

  // This projects the query onto the straight move from the current point to
  // the record's target and keeps the candidate if it beats the best so far.
  // The arithmetic is done in 128 bits, so no intermediate can overflow.
  function automatic void project_segment(input logic [2:0][31:0] tgt,
                                          input logic [2:0] tv);
    longint       ept [3];
    longint       dq, dt, off, err;
    logic [127:0] pp, pn, tt, rem, frac, dsq, sq;
    logic         blocked, usable;
    int           k;
    blocked = 1'b0;
    usable  = 1'b1;
    for (k = 0; k < 3; k++) begin
      ept[k] = longint'($signed(tgt[k]));
      if (qry_axes[k]) begin
        // A missing target coordinate stays where the path already is. If
        // that is unknown too, the record says nothing usable at all.
        if (!tv[k]) begin
          if (!pos_known[k]) blocked = 1'b1;
          else ept[k] = pos_now[k];
        end else if (!pos_known[k]) begin
          usable = 1'b0;
        end
      end
    end
    if (blocked) return;

    if (usable) begin
      // pp and pn hold the positive and negative parts of the dot product of
      // (query - start) with (end - start), and tt holds the squared length.
      pp = '0;
      pn = '0;
      tt = '0;
      for (k = 0; k < 3; k++) begin
        if (qry_axes[k]) begin
          dq = qry_pos[k] - pos_now[k];
          dt = ept[k] - pos_now[k];
          if ((dq < 0) != (dt < 0)) pn = pn + mag(dq) * mag(dt);
          else pp = pp + mag(dq) * mag(dt);
          tt = tt + mag(dt) * mag(dt);
        end
      end
      // A zero-length move, including the case with no queried axis, gives
      // no candidate.
      if (tt != 0) begin
        if (pn >= pp) begin
          frac = '0;
        end else begin
          rem = pp - pn;
          if (rem >= tt) frac = 128'(1) << FRACTION_BITS;
          else frac = (rem << FRACTION_BITS) / tt;
        end
        // The per-axis offsets are truncated toward the start point.
        dsq = '0;
        for (k = 0; k < 3; k++) begin
          if (qry_axes[k]) begin
            dq  = qry_pos[k] - pos_now[k];
            dt  = ept[k] - pos_now[k];
            off = longint'((mag(dt) * frac) >> FRACTION_BITS);
            if (dt < 0) off = -off;
            err = dq - off;
            sq  = mag(err) * mag(err);
            dsq = dsq + sq;
            if (dsq > 128'(DIST_LIMIT)) dsq = 128'(DIST_LIMIT);
          end
        end
        // A tie keeps the earlier record.
        if (!best_hit || dsq[DIST_W-1:0] < best_dsq) begin
          best_hit  = 1'b1;
          best_dsq  = dsq[DIST_W-1:0];
          best_rec  = rec_count;
          best_frac = frac[FRAC_W-1:0];
        end
      end
    end

    // The path moves on to every coordinate that the record gives.
    for (k = 0; k < 3; k++) begin
      if (tv[k]) pos_now[k] = longint'($signed(tgt[k]));
    end
    pos_known = pos_known | tv;
  endfunction

  // This advances the search by one accepted record and queues the result
  // that a final record owes.
  function automatic void track_record(input rec_t r);
    nearest_t res;
    if (r.seg) project_segment(r.tgt, r.tv);
    rec_count = rec_count + 1'b1;
    if (r.last) begin
      res = '0;
      if (best_hit) begin
        res.found = 1'b1;
        res.idx   = best_rec;
        res.frac  = best_frac;
        res.dsq   = best_dsq;
      end
      nearest_q.push_back(res);
      clear_path();
    end
  endfunction

  function automatic rec_t make_rec(input logic seg, input logic [31:0] x, y, z,
                                    input logic [2:0] tv, input logic last);
    rec_t r;
    r.seg    = seg;
    r.tgt[0] = x;
    r.tgt[1] = y;
    r.tgt[2] = z;
    r.tv     = tv;
    r.last   = last;
    return r;
  endfunction

  // Coordinates mix the range ends, a tight cluster around the origin (so
  // that many projections land inside a segment) and fully random words.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_miss(input string what, input logic [63:0] got,
                           input logic [63:0] want);
    miss_count++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, results_seen, what, got, want);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
  endtask

  // This writes all four query registers while the block is idle and keeps
  // the testbench copy in step. It returns at a falling edge, so that records
  // queued afterwards never race the driver.
  task automatic set_query(input logic [31:0] qx, qy, qz, input logic [2:0] axes);
    cfg_write(REG_QUERY_X, qx);
    cfg_write(REG_QUERY_Y, qy);
    cfg_write(REG_QUERY_Z, qz);
    cfg_write(REG_QUERY_AXIS, CFG_DATA_W'(axes));
    @(posedge clk);
    cfg_we <= 1'b0;
    qry_pos[0] = longint'($signed(qx));
    qry_pos[1] = longint'($signed(qy));
    qry_pos[2] = longint'($signed(qz));
    qry_axes   = axes;
    @(negedge clk);
  endtask

  // This waits until every queued record has been taken and every owed
  // result has come back. Then it gives the block time to finish any
  // record that produces no result.
  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || in_tvalid || nearest_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The driver presents the next queued record whenever the channel is free.
  // It holds back about one cycle in five outside the steady window. The
  // prediction is made at the edge where a beat is taken, using the query
  // copy, which only changes while the stream is empty.
  always @(posedge clk) begin
    rec_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_record({in_tuser, in_tdata[3*COORD_W-1:0],
                      in_tdata[3*COORD_W +: 3], in_tlast});
        beats_in <= beats_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
          nxt = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, nxt.tv, nxt.tgt};
          in_tuser  <= nxt.seg;
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // The monitor takes result beats and stalls about one cycle in five
  // outside the steady window. Each beat is checked field by field against
  // the oldest owed result.
  always @(posedge clk) begin
    nearest_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.found = out_tuser;
        got.idx   = out_tdata[RECORD_W-1:0];
        got.frac  = out_tdata[RECORD_W +: FRAC_W];
        got.dsq   = out_tdata[RECORD_W + FRAC_W +: DIST_W];
        if (nearest_q.size() == 0) begin
          flag_miss("unexpected beat, found", 64'(got.found), 64'd0);
        end else begin
          want = nearest_q.pop_front();
          if (got.found != want.found) flag_miss("found", 64'(got.found), 64'(want.found));
          if (got.idx != want.idx) flag_miss("record_index", 64'(got.idx), 64'(want.idx));
          if (got.frac != want.frac) flag_miss("fraction", 64'(got.frac), 64'(want.frac));
          if (got.dsq != want.dsq) flag_miss("distance_sq", 64'(got.dsq), 64'(want.dsq));
          if (want.found) hits_seen++;
        end
        results_seen++;
      end
      out_tready <= steady || ($urandom_range(99) >= 19);
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed", cycles,
               nearest_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rec_t             r;
    int               paths, len, i, rand_recs;
    logic [2:0][31:0] prev_tgt;
    logic [2:0]       axes;
    rand_recs  = 0;
    prev_tgt   = '0;
    qry_pos[0] = 0;
    qry_pos[1] = 0;
    qry_pos[2] = 0;
    qry_axes   = 3'b111;
    clear_path();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The directed part begins with the reset query at the origin on all
    // axes. First, a toolpath with no segment reports nothing found.
    pending.push_back(make_rec(1'b0, '0, '0, '0, 3'b111, 1'b1));
    // A segment with unknown current and target on y and z is skipped. One
    // with every target known but nothing current only sets the start point.
    pending.push_back(make_rec(1'b1, 32'h0001_0000, '0, '0, 3'b001, 1'b0));
    pending.push_back(make_rec(1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
                               3'b111, 1'b0));
    // The missing y and z come from the current point. The query projects to
    // the middle of the segment.
    pending.push_back(make_rec(1'b1, 32'h0001_0000, '0, '0, 3'b001, 1'b0));
    // A zero-length move gives nothing.
    pending.push_back(make_rec(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                               3'b111, 1'b0));
    // A record that is not a segment only advances the index.
    pending.push_back(make_rec(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               3'b111, 1'b0));
    // Here the query lies behind the start, then past the end.
    pending.push_back(make_rec(1'b1, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000,
                               3'b111, 1'b0));
    pending.push_back(make_rec(1'b1, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                               3'b111, 1'b0));
    // This segment ties the best distance and must not replace it.
    pending.push_back(make_rec(1'b1, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000,
                               3'b111, 1'b0));
    // This final segment passes close to the origin and wins.
    pending.push_back(make_rec(1'b1, '0, 32'h0000_8000, '0, 3'b111, 1'b1));
    drain();

    // With the query at the low corner, a short move at the high corner
    // saturates the distance. A move across the whole range then ends on
    // the query exactly, with the fraction at one.
    set_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 3'b111);
    pending.push_back(make_rec(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               3'b111, 1'b0));
    pending.push_back(make_rec(1'b1, '0, 32'h7FFF_0000, 32'h7FFF_FFFF, 3'b110, 1'b0));
    pending.push_back(make_rec(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               3'b111, 1'b1));
    drain();

    // With no queried axis, every segment has zero length.
    set_query(32'h7FFF_FFFF, '0, 32'h8000_0000, 3'b000);
    pending.push_back(make_rec(1'b1, 32'd1, 32'd2, 32'd3, 3'b111, 1'b0));
    pending.push_back(make_rec(1'b1, 32'd5, 32'd6, 32'd7, 3'b111, 1'b1));
    drain();

    // With only x and z queried, y is ignored throughout, even when unknown.
    set_query(32'h1234_5678, 32'hFEDC_BA98, '0, 3'b101);
    pending.push_back(make_rec(1'b1, '0, '0, '0, 3'b010, 1'b0));
    pending.push_back(make_rec(1'b1, 32'h1000_0000, '0, 32'h2000_0000, 3'b101, 1'b0));
    pending.push_back(make_rec(1'b1, 32'h2000_0000, 32'h5555_5555, '0, 3'b111, 1'b1));
    drain();

    // In the random part, each phase sets a fresh query and then streams a
    // handful of toolpaths. Most records are segments with every coordinate
    // given. The rest are other records, moves with coordinates missing and
    // repeated targets that give zero-length moves.
    while (rand_recs < RANDOM_RECORDS) begin
      axes = ($urandom_range(9) < 6) ? 3'b111 : 3'($urandom_range(7));
      set_query(pick_coord(), pick_coord(), pick_coord(), axes);
      paths = $urandom_range(3, 10);
      repeat (paths) begin
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 30);
        for (i = 0; i < len; i++) begin
          r.seg = ($urandom_range(9) != 0);
          if ($urandom_range(19) == 0) r.tgt = prev_tgt;
          else r.tgt = {pick_coord(), pick_coord(), pick_coord()};
          r.tv   = ($urandom_range(3) != 0) ? 3'b111 : 3'($urandom_range(7));
          r.last = (i == len - 1);
          pending.push_back(r);
          prev_tgt = r.tgt;
          rand_recs++;
        end
      end
      drain();
    end

    $display("Streamed %0d records; checked %0d results, %0d of them with a nearest point.",
             beats_in, results_seen, hits_seen);
    if (miss_count == 0 && nearest_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
